FILE: hw/rtl/wsfr_pkg.sv
// Shared types and constants of the WebSocket frame receiver.
`default_nettype none

package wsfr_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int SIZE_BITS   = 32;

   localparam logic [3:0] OPC_CONT   = 4'd0;
   localparam logic [3:0] OPC_BINARY = 4'd2;
   localparam logic [3:0] OPC_PING   = 4'd9;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [2:0] EXT16_COUNT = 3'd1;
   localparam logic [2:0] EXT64_COUNT = 3'd7;
   localparam logic [2:0] KEY_COUNT   = 3'd3;

   localparam logic ERR_UNMASKED  = 1'b0;
   localparam logic ERR_TOO_LARGE = 1'b1;

   localparam logic CSR_CLIENT_SIDE = 1'b0;
   localparam logic CSR_MAX_SIZE    = 1'b1;

   localparam logic [SIZE_BITS-1:0] MAX_SIZE_RESET = SIZE_BITS'(1024 * 1024 * 32);

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_PONG      = 2'd1,
      KIND_ERROR     = 2'd2,
      KIND_EMPTY_END = 2'd3
   } kind_type;

   typedef struct packed {
      logic                 client_side;
      logic [SIZE_BITS-1:0] max_message_size;
   } cfg_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] data_byte;
      logic [3:0] message_opcode;
      logic       end_of_message;
      logic       error_code;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/wsfr_if.sv
// Valid/ready channel interfaces for received bytes and results.
`default_nettype none

interface wsfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] data_byte;
   logic [3:0] message_opcode;
   logic       end_of_message;
   logic       error_code;

   modport source (output valid, output result_kind, output data_byte,
                   output message_opcode, output end_of_message, output error_code,
                   input ready);
   modport sink (input valid, input result_kind, input data_byte,
                 input message_opcode, input end_of_message, input error_code,
                 output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wsfr_csr.sv
// Configuration registers of the WebSocket frame receiver.
`default_nettype none

module wsfr_csr
   import wsfr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic                 csr_index,
   input  wire logic [SIZE_BITS-1:0] csr_wdata,
   output cfg_type                   cfg
);

   logic                 client_side_ff;
   logic [SIZE_BITS-1:0] size_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         client_side_ff <= 1'b0;
         size_limit_ff  <= MAX_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLIENT_SIDE: client_side_ff <= csr_wdata[0];
            CSR_MAX_SIZE:    size_limit_ff  <= csr_wdata;
            default:         client_side_ff <= client_side_ff;
         endcase
      end
   end

   assign cfg.client_side      = client_side_ff;
   assign cfg.max_message_size = size_limit_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/wsfr_parser.sv
// Frame header parser, payload unmasking and message bookkeeping.
`default_nettype none

module wsfr_parser
   import wsfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output logic            res_valid,
   output rsp_type         res
);

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             opc_ff, opc_in;
   logic                   masked_ff, masked_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [2:0]             count_ff, count_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             mpos_ff, mpos_in;
   logic [SIZE_BITS-1:0]   msg_len_ff, msg_len_in;
   logic [3:0]             msg_opc_ff, msg_opc_in;
   logic                   halted_ff, halted_in;
   logic                   ovf_ff, ovf_in;

   logic                   is_data;
   logic [6:0]             len7;
   logic                   do_len;
   logic                   do_begin;
   logic                   rem_hi_nz;
   logic [SIZE_BITS:0]     total;
   logic [7:0]             key_byte;
   logic [LENGTH_BITS-1:0] rem_dec;

   assign is_data  = (opc_ff <= OPC_BINARY);
   assign len7     = rx_byte[6:0];
   assign key_byte = 8'(key_ff >> {~mpos_ff, 3'b000});
   assign rem_dec  = (rem_ff != '0) ? rem_ff - LENGTH_BITS'(1) : rem_ff;

   always_comb begin
      phase_in   = phase_ff;
      fin_in     = fin_ff;
      opc_in     = opc_ff;
      masked_in  = masked_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      mpos_in    = mpos_ff;
      msg_len_in = msg_len_ff;
      msg_opc_in = msg_opc_ff;
      halted_in  = halted_ff;
      ovf_in     = ovf_ff;
      res_valid  = 1'b0;
      res        = '0;
      do_len     = 1'b0;
      do_begin   = 1'b0;
      rem_hi_nz  = 1'b0;
      total      = '0;

      if (!halted_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in   = rx_byte[7];
               opc_in   = rx_byte[3:0];
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               masked_in = rx_byte[7];
               key_in    = '0;
               mpos_in   = '0;
               rem_in    = '0;
               ovf_in    = 1'b0;
               if (is_data && !cfg.client_side && !rx_byte[7]) begin
                  halted_in       = 1'b1;
                  res_valid       = 1'b1;
                  res.result_kind = KIND_ERROR;
                  res.error_code  = ERR_UNMASKED;
               end else begin
                  if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
                     count_in = (len7 == LEN7_EXT16) ? EXT16_COUNT : EXT64_COUNT;
                     phase_in = PH_EXTLEN;
                  end else begin
                     rem_in = LENGTH_BITS'(len7);
                  end
                  if (opc_ff == OPC_PING) begin
                     if (!(len7 == LEN7_EXT16 || len7 == LEN7_EXT64)) begin
                        if (rx_byte[7]) begin
                           phase_in = PH_MASK;
                           count_in = KEY_COUNT;
                        end else begin
                           phase_in = (len7 != '0) ? PH_PAYLOAD : PH_HDR0;
                        end
                     end
                     res_valid       = 1'b1;
                     res.result_kind = KIND_PONG;
                  end else if (!(len7 == LEN7_EXT16 || len7 == LEN7_EXT64)) begin
                     do_len = 1'b1;
                  end
               end
            end
            PH_EXTLEN: begin
               ovf_in = ovf_ff | ((rem_ff >> (LENGTH_BITS - 8)) != '0);
               rem_in = {rem_ff[LENGTH_BITS-9:0], rx_byte};
               if (count_ff != '0) begin
                  count_in = count_ff - 3'd1;
               end else if (opc_ff == OPC_PING) begin
                  if (ovf_in) begin
                     halted_in       = 1'b1;
                     res_valid       = 1'b1;
                     res.result_kind = KIND_ERROR;
                     res.error_code  = ERR_TOO_LARGE;
                  end else if (masked_ff) begin
                     phase_in = PH_MASK;
                     count_in = KEY_COUNT;
                  end else begin
                     phase_in = (rem_in != '0) ? PH_PAYLOAD : PH_HDR0;
                  end
               end else begin
                  do_len = 1'b1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], rx_byte};
               if (count_ff != '0) begin
                  count_in = count_ff - 3'd1;
               end else begin
                  do_begin = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               mpos_in = mpos_ff + 2'd1;
               rem_in  = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_HDR0;
                  if (is_data && fin_ff) begin
                     res.end_of_message = 1'b1;
                     msg_len_in         = '0;
                     msg_opc_in         = OPC_CONT;
                  end
               end
               if (is_data) begin
                  res_valid          = 1'b1;
                  res.result_kind    = KIND_DATA;
                  res.data_byte      = rx_byte ^ key_byte;
                  res.message_opcode = msg_opc_ff;
               end else begin
                  res.end_of_message = 1'b0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         // length known: overflow and message size check
         if (do_len) begin
            rem_hi_nz = ((rem_in >> 32) != '0);
            total     = {1'b0, msg_len_ff} + {1'b0, SIZE_BITS'(rem_in)};
            if (ovf_in || (is_data && (rem_hi_nz || total >= {1'b0, cfg.max_message_size})))
            begin
               halted_in       = 1'b1;
               res_valid       = 1'b1;
               res.result_kind = KIND_ERROR;
               res.error_code  = ERR_TOO_LARGE;
            end else begin
               if (is_data) begin
                  msg_len_in = total[SIZE_BITS-1:0];
                  if (msg_opc_ff == OPC_CONT && opc_ff != OPC_CONT) begin
                     msg_opc_in = opc_ff;
                  end
               end
               if (masked_in) begin
                  phase_in = PH_MASK;
                  count_in = KEY_COUNT;
               end else begin
                  do_begin = 1'b1;
               end
            end
         end

         if (do_begin) begin
            mpos_in  = '0;
            phase_in = (rem_in != '0) ? PH_PAYLOAD : PH_HDR0;
            if (rem_in == '0 && is_data && fin_ff) begin
               res_valid          = 1'b1;
               res.result_kind    = KIND_EMPTY_END;
               res.message_opcode = msg_opc_in;
               res.end_of_message = 1'b1;
               msg_len_in         = '0;
               msg_opc_in         = OPC_CONT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         fin_ff     <= 1'b0;
         opc_ff     <= '0;
         masked_ff  <= 1'b0;
         rem_ff     <= '0;
         count_ff   <= '0;
         key_ff     <= '0;
         mpos_ff    <= '0;
         msg_len_ff <= '0;
         msg_opc_ff <= '0;
         halted_ff  <= 1'b0;
         ovf_ff     <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         opc_ff     <= opc_in;
         masked_ff  <= masked_in;
         rem_ff     <= rem_in;
         count_ff   <= count_in;
         key_ff     <= key_in;
         mpos_ff    <= mpos_in;
         msg_len_ff <= msg_len_in;
         msg_opc_ff <= msg_opc_in;
         halted_ff  <= halted_in;
         ovf_ff     <= ovf_in;
      end
   end

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      step && halted_ff |-> !res_valid)
      else $error("result produced while halted");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.result_kind == KIND_ERROR |=> halted_ff)
      else $error("error result without halt");

   a_eom_clears: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.end_of_message |=> msg_len_ff == '0 && msg_opc_ff == OPC_CONT)
      else $error("message state not cleared at end of message");

endmodule

`default_nettype wire

FILE: hw/rtl/websocket_frame_receiver.sv
// Top level of the WebSocket frame receiver: input register, parser, result register.
// Takes one received byte per clock cycle unless the result side stalls. An accepted byte
// sits in the input register while the parser updates its state and forms at most
// one result, which lands in the result register; rsp_chan.valid therefore rises once
// that register is loaded. The input register refills in the same cycle
// a result is taken, so stalls on the result side hold back input only when both
// registers are full. After an error result the block drops all further bytes until
// reset. Configuration writes must happen only while no byte is in flight.
`default_nettype none

module websocket_frame_receiver
   import wsfr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   wsfr_req_if.sink                  req_chan,
   wsfr_rsp_if.source                rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic                 csr_index,
   input  wire logic [SIZE_BITS-1:0] csr_wdata
);

   cfg_type    cfg;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;
   logic       advance;
   logic       res_valid;
   rsp_type    res;

   wsfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wsfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= res_valid;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.result_kind    = out_ff.result_kind;
   assign rsp_chan.data_byte      = out_ff.data_byte;
   assign rsp_chan.message_opcode = out_ff.message_opcode;
   assign rsp_chan.end_of_message = out_ff.end_of_message;
   assign rsp_chan.error_code     = out_ff.error_code;

endmodule

`default_nettype wire
